@@ rtl/core/eei_pkg.sv @@
package eei_pkg;

    // Operand and coefficient widths fixed by the item format
    localparam int unsigned OPW    = 31;
    localparam int unsigned COEFW  = 32;
    localparam int unsigned CNTW   = $clog2(OPW);
    localparam logic [CNTW-1:0] DIV_LAST = CNTW'(OPW - 1);

    // Controller state, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_DIV   = 6'b000100,
        S_MUL   = 6'b001000,
        S_UPD   = 6'b010000,
        S_WAIT  = 6'b100000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic mul;
        logic upd;
        logic out_load;
    } t_eei_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic cur_one;
        logic cur_zero;
        logic div_last;
    } t_eei_sts;

endpackage

@@ rtl/core/eei_datapath.sv @@
module eei_datapath
    import eei_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic [OPW-1:0]               i_first_value,
    input  logic [OPW-1:0]               i_second_value,
    input  t_eei_cmd                     i_cmd,
    output t_eei_sts                     o_sts,
    output logic signed [DATA_WIDTH-1:0] o_answer,
    output logic                         o_coprime
);

    // Remainder and coefficient rows
    logic [OPW-1:0]          r_prev, n_prev;
    logic [OPW-1:0]          r_cur, n_cur;
    logic signed [COEFW-1:0] r_cprev, n_cprev;
    logic signed [COEFW-1:0] r_ccur, n_ccur;
    // Divider: partial remainder, dividend/quotient shift register, step count
    logic [OPW-1:0]          r_rem, n_rem;
    logic [OPW-1:0]          r_quo, n_quo;
    logic [CNTW-1:0]         r_cnt, n_cnt;
    // Low half of q * c_cur
    logic [COEFW-1:0]        r_prod, n_prod;
    // Result register
    logic signed [DATA_WIDTH-1:0] r_answer, n_answer;
    logic                    r_coprime, n_coprime;

    logic [OPW:0]            trial;
    logic                    fits;

    // One restoring-division step
    assign trial = {r_rem, r_quo[OPW-1]};
    assign fits  = (trial >= {1'b0, r_cur});

    always_comb begin
        n_prev    = r_prev;
        n_cur     = r_cur;
        n_cprev   = r_cprev;
        n_ccur    = r_ccur;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_prod    = r_prod;
        n_answer  = r_answer;
        n_coprime = r_coprime;

        // larger value becomes the modulus, second wins a tie
        if (i_cmd.load) begin
            if (i_first_value > i_second_value) begin
                n_prev = i_first_value;
                n_cur  = i_second_value;
            end else begin
                n_prev = i_second_value;
                n_cur  = i_first_value;
            end
            n_cprev = '0;
            n_ccur  = COEFW'(1);
        end

        if (i_cmd.div_start) begin
            n_rem = '0;
            n_quo = r_prev;
            n_cnt = '0;
        end

        if (i_cmd.div_step) begin
            if (fits) begin
                n_rem = OPW'(trial - {1'b0, r_cur});
            end else begin
                n_rem = OPW'(trial);
            end
            n_quo = {r_quo[OPW-2:0], fits};
            n_cnt = r_cnt + CNTW'(1);
        end

        // true coefficient fits in 32 signed bits, so the low product half suffices
        if (i_cmd.mul) begin
            n_prod = COEFW'(COEFW'(r_quo) * COEFW'(r_ccur));
        end

        if (i_cmd.upd) begin
            n_prev  = r_cur;
            n_cur   = r_rem;
            n_cprev = r_ccur;
            n_ccur  = r_cprev - $signed(r_prod);
        end

        if (i_cmd.out_load) begin
            if (o_sts.cur_one) begin
                n_answer  = DATA_WIDTH'(r_ccur);
                n_coprime = 1'b1;
            end else begin
                n_answer  = DATA_WIDTH'(r_prev);
                n_coprime = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev    <= n_prev;
        r_cur     <= n_cur;
        r_cprev   <= n_cprev;
        r_ccur    <= n_ccur;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_cnt     <= n_cnt;
        r_prod    <= n_prod;
        r_answer  <= n_answer;
        r_coprime <= n_coprime;
    end

    assign o_sts.cur_one  = (r_cur == OPW'(1));
    assign o_sts.cur_zero = (r_cur == '0);
    assign o_sts.div_last = (r_cnt == DIV_LAST);
    assign o_answer       = r_answer;
    assign o_coprime      = r_coprime;

endmodule

@@ rtl/core/eei_ctrl.sv @@
module eei_ctrl
    import eei_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_eei_sts i_sts,
    output t_eei_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   done;
    logic   out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign done     = i_sts.cur_one || i_sts.cur_zero;
    assign out_free = !r_out_valid || i_ready;

    // Sequencer: check, divide, multiply, update per Euclid step
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (done) begin
                    if (out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_state = S_WAIT;
                    end
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_WAIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid: set on result load, cleared when the item is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef ASSERT_OFF
    // result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_ready))
        else $error("result overwritten while stalled");

    // divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !i_sts.cur_zero)
        else $error("division by zero remainder");

    // multiply follows the last division step only
    a_mul_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && i_sts.div_last |=> (r_state == S_MUL))
        else $error("multiply did not follow division");

    // accepted item goes straight to the remainder check
    a_accept_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_CHECK))
        else $error("accepted item not checked");
`endif

endmodule

@@ rtl/core/extended_euclid_inverse_core.sv @@
// Extended Euclidean modular inverse core.
// Input channel: i_valid / o_ready carry i_first_value and i_second_value,
// two 31-bit unsigned operands. The larger is the modulus, the other the
// operand (second wins a tie). Output channel: o_valid / i_ready carry
// o_answer and o_coprime. With o_coprime high, o_answer is the signed,
// unreduced Bezout coefficient of the smaller operand (its inverse modulo
// the larger); with o_coprime low it is the gcd.
// Each Euclid step runs a remainder check, a bit-serial radix-2 restoring
// division, a multiply and a row update. Up to about 46 steps for 31-bit
// operands. One item is in work at a time; o_ready is high while the core
// is idle.
// The result sits in an output register: a new item is accepted while an
// earlier result waits, and a finished item holds in the core until the
// receiver takes the pending one.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle and drops
// o_valid; nothing is kept between items.
module extended_euclid_inverse_core
    import eei_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [OPW-1:0]               i_first_value,
    input  logic [OPW-1:0]               i_second_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [DATA_WIDTH-1:0] o_answer,
    output logic                         o_coprime
);

    t_eei_cmd cmd;
    t_eei_sts sts;

    eei_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    eei_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_first_value  (i_first_value),
        .i_second_value (i_second_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_answer       (o_answer),
        .o_coprime      (o_coprime)
    );

endmodule
